// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

// ----- hw/rtl/tlqe_pkg.sv -----
package tlqe_pkg;

	localparam int COORD_W   = 16;
	localparam int THICK_W   = 12;
	localparam int LEN_EXTRA = 14;
	localparam int ABS_W     = 16;
	localparam int SQ_W      = 2 * ABS_W;
	localparam int AT_W      = ABS_W + THICK_W;
	localparam int L2_W      = SQ_W + 1;
	localparam int LRAD_W    = 62;
	localparam int LEN_W     = LRAD_W / 2;
	localparam int NUM_W     = 44;
	localparam int DEN_W     = LEN_W + 1;
	localparam int QUO_W     = 13;
	localparam int NRM_W     = QUO_W + 1;
	localparam int CRN_W     = 18;
	localparam int RABS_W    = 17;
	localparam int R2_W      = 2 * RABS_W + 1;
	localparam int RRAD_W    = R2_W + 1;
	localparam int RROOT_W   = RRAD_W / 2;
	localparam int RREM_W    = RROOT_W + 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 176;
	localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(2048);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CRN_W-1:0]   crn_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		coord_t cx;
		coord_t cy;
		logic   dy_pos;
		logic   dx_neg;
		logic   deg;
	} geom_t;

	typedef struct packed {
		geom_t           g;
		logic [AT_W-1:0] aty;
		logic [AT_W-1:0] atx;
	} lenband_t;

	typedef struct packed {
		crn_t   c0x;
		crn_t   c0y;
		crn_t   c1x;
		crn_t   c1y;
		crn_t   c2x;
		crn_t   c2y;
		crn_t   c3x;
		crn_t   c3y;
		coord_t cx;
		coord_t cy;
		logic   deg;
	} quad_t;

	function automatic coord_t sat16(input crn_t v);
		coord_t r;
		if (v > crn_t'(32767)) begin
			r = coord_t'(32767);
		end else if (v < -crn_t'(32768)) begin
			r = -coord_t'(32767) - coord_t'(1);
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/tlqe_sqrt.sv -----
module tlqe_sqrt #(
	parameter int RAD_W = 62,
	parameter int SB_W  = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ce,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     in_rad,
	input  logic [SB_W-1:0]      in_sb,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   out_root,
	output logic [RAD_W/2+2:0]   out_rem,
	output logic [SB_W-1:0]      out_sb
);

	localparam int RW    = RAD_W / 2;
	localparam int REM_W = RW + 3;

	logic [RAD_W-1:0] rad_sk  [RW];
	logic [REM_W-1:0] rem_sk  [RW];
	logic [RW-1:0]    root_sk [RW];
	logic [SB_W-1:0]  sb_sk   [RW];
	logic [RW-1:0]    vld_sk;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RAD_W-1:0] rad_p;
		logic [REM_W-1:0] rem_p;
		logic [RW-1:0]    root_p;
		logic [SB_W-1:0]  sb_p;
		logic             vld_p;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rad_p  = in_rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign sb_p   = in_sb;
			assign vld_p  = in_valid;
		end else begin : g_next
			assign rad_p  = rad_sk[k-1];
			assign rem_p  = rem_sk[k-1];
			assign root_p = root_sk[k-1];
			assign sb_p   = sb_sk[k-1];
			assign vld_p  = vld_sk[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (ce) begin
				vld_sk[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rad_sk[k] <= rad_p << 2;
				sb_sk[k]  <= sb_p;
				if (cur >= trial) begin
					rem_sk[k]  <= cur - trial;
					root_sk[k] <= {root_p[RW-2:0], 1'b1};
				end else begin
					rem_sk[k]  <= cur;
					root_sk[k] <= {root_p[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_sk[RW-1];
	assign out_root  = root_sk[RW-1];
	assign out_rem   = rem_sk[RW-1];
	assign out_sb    = sb_sk[RW-1];

endmodule

// ----- hw/rtl/tlqe_div2.sv -----
module tlqe_div2 #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 32,
	parameter int QW    = 13,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num_a,
	input  logic [NUM_W-1:0] in_num_b,
	input  logic [DEN_W-1:0] in_den,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_valid,
	output logic [QW-1:0]    out_qa,
	output logic [QW-1:0]    out_qb,
	output logic [SB_W-1:0]  out_sb
);

	localparam int WW = DEN_W + QW;

	logic [WW-1:0]    ra_sk  [QW];
	logic [WW-1:0]    rb_sk  [QW];
	logic [DEN_W-1:0] den_sk [QW];
	logic [QW-1:0]    qa_sk  [QW];
	logic [QW-1:0]    qb_sk  [QW];
	logic [SB_W-1:0]  sb_sk  [QW];
	logic [QW-1:0]    vld_sk;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic [WW-1:0]    ra_p;
		logic [WW-1:0]    rb_p;
		logic [DEN_W-1:0] den_p;
		logic [QW-1:0]    qa_p;
		logic [QW-1:0]    qb_p;
		logic [SB_W-1:0]  sb_p;
		logic             vld_p;
		logic [WW-1:0]    dsh;

		if (k == 0) begin : g_first
			assign ra_p  = WW'(in_num_a);
			assign rb_p  = WW'(in_num_b);
			assign den_p = in_den;
			assign qa_p  = '0;
			assign qb_p  = '0;
			assign sb_p  = in_sb;
			assign vld_p = in_valid;
		end else begin : g_next
			assign ra_p  = ra_sk[k-1];
			assign rb_p  = rb_sk[k-1];
			assign den_p = den_sk[k-1];
			assign qa_p  = qa_sk[k-1];
			assign qb_p  = qb_sk[k-1];
			assign sb_p  = sb_sk[k-1];
			assign vld_p = vld_sk[k-1];
		end

		assign dsh = WW'(den_p) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (ce) begin
				vld_sk[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				den_sk[k] <= den_p;
				sb_sk[k]  <= sb_p;
				if (ra_p >= dsh) begin
					ra_sk[k] <= ra_p - dsh;
					qa_sk[k] <= {qa_p[QW-2:0], 1'b1};
				end else begin
					ra_sk[k] <= ra_p;
					qa_sk[k] <= {qa_p[QW-2:0], 1'b0};
				end
				if (rb_p >= dsh) begin
					rb_sk[k] <= rb_p - dsh;
					qb_sk[k] <= {qb_p[QW-2:0], 1'b1};
				end else begin
					rb_sk[k] <= rb_p;
					qb_sk[k] <= {qb_p[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_sk[QW-1];
	assign out_qa    = qa_sk[QW-1];
	assign out_qb    = qb_sk[QW-1];
	assign out_sb    = sb_sk[QW-1];

endmodule

// ----- hw/rtl/thick_line_quad_expander.sv -----
// Channel  Dir  Group                    Content
// s_axis   in   s_tvalid/s_tready/tdata  one segment word: ends and thickness
// m_axis   out  m_tvalid/m_tready/tdata  four corners, circle, degenerate on tuser
//
// One segment per cycle while m_axis is not stalled.
// Latency is set by the two bit-per-stage square roots (31 and 18 stages) and
// the 13-stage restoring divider for the two normal components.
// Reset clears only the valid bits of every stage and m_tvalid.
// A stall on m_axis freezes the whole pipeline in place; s_tready drops with it.
`include "assert_macros.svh"

module thick_line_quad_expander (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// start_x, start_y, end_x, end_y, line_thickness, zero pad
	input  logic [tlqe_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// corner0_x, corner0_y, corner1_x .. corner3_y, circle_cx, circle_cy, circle_radius
	output logic [tlqe_pkg::OUT_DATA_W-1:0]    m_tdata,
	// degenerate
	output logic [0:0]                         m_tuser
);

	localparam int CW  = tlqe_pkg::COORD_W;
	localparam int LBW = $bits(tlqe_pkg::lenband_t);
	localparam int GW  = $bits(tlqe_pkg::geom_t);
	localparam int QDW = $bits(tlqe_pkg::quad_t);

	logic ce;
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	// ---- stage 1: differences, centre, flags
	tlqe_pkg::coord_t in_sx, in_sy, in_ex, in_ey;
	logic [tlqe_pkg::THICK_W-1:0] in_t;
	logic signed [CW:0]   dx, dy;
	logic [CW:0]          adx_w, ady_w;
	logic signed [CW+1:0] sumx, sumy;
	tlqe_pkg::geom_t      g_in;

	assign in_sx = s_tdata[15:0];
	assign in_sy = s_tdata[31:16];
	assign in_ex = s_tdata[47:32];
	assign in_ey = s_tdata[63:48];
	assign in_t  = s_tdata[75:64];

	assign dx    = (CW+1)'(in_ex) - (CW+1)'(in_sx);
	assign dy    = (CW+1)'(in_ey) - (CW+1)'(in_sy);
	assign adx_w = dx[CW] ? -dx : dx;
	assign ady_w = dy[CW] ? -dy : dy;
	// floor((sx + ex + 1) / 2) is the mean of the four corners, rounded
	assign sumx  = (CW+2)'(in_sx) + (CW+2)'(in_ex) + (CW+2)'(1);
	assign sumy  = (CW+2)'(in_sy) + (CW+2)'(in_ey) + (CW+2)'(1);

	always_comb begin
		g_in.sx     = in_sx;
		g_in.sy     = in_sy;
		g_in.ex     = in_ex;
		g_in.ey     = in_ey;
		g_in.cx     = sumx[CW:1];
		g_in.cy     = sumy[CW:1];
		g_in.dy_pos = !dy[CW] && (dy != '0);
		g_in.dx_neg = dx[CW];
		g_in.deg    = (dx == '0) && (dy == '0);
	end

	logic                               v_s1;
	tlqe_pkg::geom_t                    g_s1;
	logic [tlqe_pkg::ABS_W-1:0]         adx_s1, ady_s1;
	logic [tlqe_pkg::THICK_W-1:0]       t_s1;

	// ---- stage 2: squares and thickness products
	logic                               v_s2;
	tlqe_pkg::geom_t                    g_s2;
	logic [tlqe_pkg::SQ_W-1:0]          ax2_s2, ay2_s2;
	logic [tlqe_pkg::AT_W-1:0]          aty_s2, atx_s2;

	// ---- stage 3: squared length
	logic                               v_s3;
	tlqe_pkg::lenband_t                 lb_s3;
	logic [tlqe_pkg::L2_W-1:0]          l2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			g_s1   <= g_in;
			adx_s1 <= adx_w[tlqe_pkg::ABS_W-1:0];
			ady_s1 <= ady_w[tlqe_pkg::ABS_W-1:0];
			t_s1   <= in_t;

			g_s2   <= g_s1;
			ax2_s2 <= adx_s1 * adx_s1;
			ay2_s2 <= ady_s1 * ady_s1;
			aty_s2 <= ady_s1 * t_s1;
			atx_s2 <= adx_s1 * t_s1;

			lb_s3.g   <= g_s2;
			lb_s3.aty <= aty_s2;
			lb_s3.atx <= atx_s2;
			l2_s3     <= tlqe_pkg::L2_W'(ax2_s2) + tlqe_pkg::L2_W'(ay2_s2);
		end
	end

	// ---- length with extra fraction bits
	logic [tlqe_pkg::LRAD_W-1:0] lrad;
	logic                        sq1_vld;
	logic [tlqe_pkg::LEN_W-1:0]  len;
	logic [LBW-1:0]              sq1_sb;
	tlqe_pkg::lenband_t          lb_o;

	assign lrad = {l2_s3, {(2*tlqe_pkg::LEN_EXTRA){1'b0}}, 1'b0} >> 1;

	tlqe_sqrt #(
		.RAD_W (tlqe_pkg::LRAD_W),
		.SB_W  (LBW)
	) u_len_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s3),
		.in_rad    (lrad),
		.in_sb     (lb_s3),
		.out_valid (sq1_vld),
		.out_root  (len),
		.out_rem   (),
		.out_sb    (sq1_sb)
	);

	assign lb_o = tlqe_pkg::lenband_t'(sq1_sb);

	// ---- stage 4: rounded-division operands
	logic                        v_s4;
	tlqe_pkg::geom_t             g_s4;
	logic [tlqe_pkg::NUM_W-1:0]  na_s4, nb_s4;
	logic [tlqe_pkg::DEN_W-1:0]  den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s4 <= sq1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			g_s4   <= lb_o.g;
			na_s4  <= tlqe_pkg::NUM_W'({lb_o.aty, {tlqe_pkg::LEN_EXTRA{1'b0}}})
				+ tlqe_pkg::NUM_W'(len);
			nb_s4  <= tlqe_pkg::NUM_W'({lb_o.atx, {tlqe_pkg::LEN_EXTRA{1'b0}}})
				+ tlqe_pkg::NUM_W'(len);
			den_s4 <= {len, 1'b0};
		end
	end

	logic                        dv_vld;
	logic [tlqe_pkg::QUO_W-1:0]  qa, qb;
	logic [GW-1:0]               dv_sb;
	tlqe_pkg::geom_t             g_d;

	tlqe_div2 #(
		.NUM_W (tlqe_pkg::NUM_W),
		.DEN_W (tlqe_pkg::DEN_W),
		.QW    (tlqe_pkg::QUO_W),
		.SB_W  (GW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s4),
		.in_num_a  (na_s4),
		.in_num_b  (nb_s4),
		.in_den    (den_s4),
		.in_sb     (g_s4),
		.out_valid (dv_vld),
		.out_qa    (qa),
		.out_qb    (qb),
		.out_sb    (dv_sb)
	);

	assign g_d = tlqe_pkg::geom_t'(dv_sb);

	// ---- stage 5: corners and corner-0 offset from centre
	logic signed [tlqe_pkg::NRM_W-1:0] nx, ny;
	tlqe_pkg::crn_t c0x, c0y;
	tlqe_pkg::quad_t q_in;

	assign nx  = g_d.dy_pos ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
	assign ny  = g_d.dx_neg ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
	assign c0x = tlqe_pkg::CRN_W'(g_d.sx) + tlqe_pkg::CRN_W'(nx);
	assign c0y = tlqe_pkg::CRN_W'(g_d.sy) + tlqe_pkg::CRN_W'(ny);

	always_comb begin
		q_in.c0x = c0x;
		q_in.c0y = c0y;
		q_in.c1x = tlqe_pkg::CRN_W'(g_d.ex) + tlqe_pkg::CRN_W'(nx);
		q_in.c1y = tlqe_pkg::CRN_W'(g_d.ey) + tlqe_pkg::CRN_W'(ny);
		q_in.c2x = tlqe_pkg::CRN_W'(g_d.ex) - tlqe_pkg::CRN_W'(nx);
		q_in.c2y = tlqe_pkg::CRN_W'(g_d.ey) - tlqe_pkg::CRN_W'(ny);
		q_in.c3x = tlqe_pkg::CRN_W'(g_d.sx) - tlqe_pkg::CRN_W'(nx);
		q_in.c3y = tlqe_pkg::CRN_W'(g_d.sy) - tlqe_pkg::CRN_W'(ny);
		q_in.cx  = g_d.cx;
		q_in.cy  = g_d.cy;
		q_in.deg = g_d.deg;
	end

	logic                              v_s5, v_s6, v_s7, v_s8;
	tlqe_pkg::quad_t                   q_s5, q_s6, q_s7, q_s8;
	tlqe_pkg::crn_t                    rx_s5, ry_s5;
	logic [tlqe_pkg::RABS_W-1:0]       rxa_s6, rya_s6;
	logic [2*tlqe_pkg::RABS_W-1:0]     rx2_s7, ry2_s7;
	logic [tlqe_pkg::R2_W-1:0]         r2_s8;
	tlqe_pkg::crn_t                    rxn, ryn;

	assign rxn = -rx_s5;
	assign ryn = -ry_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (ce) begin
			v_s5 <= dv_vld;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q_s5  <= q_in;
			rx_s5 <= c0x - tlqe_pkg::CRN_W'(g_d.cx);
			ry_s5 <= c0y - tlqe_pkg::CRN_W'(g_d.cy);

			q_s6   <= q_s5;
			rxa_s6 <= rx_s5[tlqe_pkg::CRN_W-1] ? rxn[tlqe_pkg::RABS_W-1:0]
				: rx_s5[tlqe_pkg::RABS_W-1:0];
			rya_s6 <= ry_s5[tlqe_pkg::CRN_W-1] ? ryn[tlqe_pkg::RABS_W-1:0]
				: ry_s5[tlqe_pkg::RABS_W-1:0];

			q_s7   <= q_s6;
			rx2_s7 <= rxa_s6 * rxa_s6;
			ry2_s7 <= rya_s6 * rya_s6;

			q_s8  <= q_s7;
			r2_s8 <= tlqe_pkg::R2_W'(rx2_s7) + tlqe_pkg::R2_W'(ry2_s7);
		end
	end

	// ---- radius
	logic                          sq2_vld;
	logic [tlqe_pkg::RROOT_W-1:0]  rroot;
	logic [tlqe_pkg::RREM_W-1:0]   rrem;
	logic [QDW-1:0]                sq2_sb;
	tlqe_pkg::quad_t               q_o;

	tlqe_sqrt #(
		.RAD_W (tlqe_pkg::RRAD_W),
		.SB_W  (QDW)
	) u_rad_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s8),
		.in_rad    (tlqe_pkg::RRAD_W'(r2_s8)),
		.in_sb     (q_s8),
		.out_valid (sq2_vld),
		.out_root  (rroot),
		.out_rem   (rrem),
		.out_sb    (sq2_sb)
	);

	assign q_o = tlqe_pkg::quad_t'(sq2_sb);

	// ---- output word: round radius to nearest, saturate, zero on degenerate
	logic [tlqe_pkg::RROOT_W:0] rnd;
	logic [CW-1:0]              rad16;
	logic [tlqe_pkg::OUT_DATA_W-1:0] word;

	assign rnd   = {1'b0, rroot}
		+ (tlqe_pkg::RROOT_W+1)'(rrem > tlqe_pkg::RREM_W'(rroot));
	assign rad16 = (rnd > (tlqe_pkg::RROOT_W+1)'(65535)) ? {CW{1'b1}} : rnd[CW-1:0];

	always_comb begin
		word = {rad16,
			q_o.cy, q_o.cx,
			tlqe_pkg::sat16(q_o.c3y), tlqe_pkg::sat16(q_o.c3x),
			tlqe_pkg::sat16(q_o.c2y), tlqe_pkg::sat16(q_o.c2x),
			tlqe_pkg::sat16(q_o.c1y), tlqe_pkg::sat16(q_o.c1x),
			tlqe_pkg::sat16(q_o.c0y), tlqe_pkg::sat16(q_o.c0x)};
		if (q_o.deg) begin
			word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ce) begin
			m_tvalid <= sq2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tdata    <= word;
			m_tuser[0] <= q_o.deg;
		end
	end

	`ASSERT_CLK(a_deg_zero, clk, arst_n, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
	`ASSERT_CLK(a_norm_bound, clk, arst_n, (dv_vld && !g_d.deg) |-> ((qa <= tlqe_pkg::QUO_MAX) && (qb <= tlqe_pkg::QUO_MAX)))
	`ASSERT_NEXT(a_hold_mid, clk, arst_n, !ce, $stable(v_s5) && $stable(v_s4))

endmodule
